/* hw/rtl/nfcdf_pkg.sv */
// Shared types and codes for the NFC frame deframer.
// Used by nfcdf_core, nfcdf_out_reg and nfc_frame_deframer; no dependencies.
package nfcdf_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NOT_READY = 2'd1;
    localparam logic [1:0] ERR_LCS       = 2'd2;
    localparam logic [1:0] ERR_DCS       = 2'd3;

    // Parser phases.
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LCS     = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_DCS     = 3'd4;
    localparam logic [2:0] PH_ACKPOST = 3'd5;

    localparam logic [7:0]  READY_STATUS = 8'h01;
    localparam logic [15:0] WINDOW_EMPTY = 16'hFFFF;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic [7:0] frame_len;
        logic [1:0] error_code;
    } t_result;

endpackage

/* hw/rtl/nfcdf_core.sv */
// Frame parser: phase, hunt window, length and running checksum state.
// Depends on nfcdf_pkg; processes one registered byte per step.
module nfcdf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_read_start,
    output logic                o_has_result,
    output nfcdf_pkg::t_result  o_result
);
    import nfcdf_pkg::*;

    logic [15:0] r_window, n_window;
    logic [2:0]  r_phase, n_phase;
    logic        r_accepted, n_accepted;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  left_dec;
    logic [7:0]  lcs_sum;
    logic [7:0]  dcs_sum;

    assign left_dec = r_left - 8'd1;
    assign lcs_sum  = r_len + i_rx_byte;
    assign dcs_sum  = r_sum + i_rx_byte;

    always_comb begin
        n_window     = r_window;
        n_phase      = r_phase;
        n_accepted   = r_accepted;
        n_len        = r_len;
        n_left       = r_left;
        n_sum        = r_sum;
        o_has_result = 1'b0;
        o_result     = '{result_kind: KIND_PAYLOAD, out_byte: 8'h00,
                         frame_len: 8'h00, error_code: ERR_NONE};

        if (i_read_start) begin
            // A new read drops any frame in progress and restarts the hunt.
            n_phase  = PH_HUNT;
            n_window = WINDOW_EMPTY;
            if (i_rx_byte == READY_STATUS) begin
                n_accepted = 1'b1;
            end else begin
                n_accepted           = 1'b0;
                o_has_result         = 1'b1;
                o_result.result_kind = KIND_ERROR;
                o_result.error_code  = ERR_NOT_READY;
            end
        end else if (r_accepted) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_window == 16'h0000 && i_rx_byte == 8'hFF) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_window = {r_window[7:0], i_rx_byte};
                    end
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_phase = PH_LCS;
                end
                PH_LCS: begin
                    if (lcs_sum == 8'h00) begin
                        n_sum   = 8'h00;
                        n_left  = r_len;
                        n_phase = (r_len == 8'h00) ? PH_DCS : PH_DATA;
                    end else if (r_len == 8'h00 && i_rx_byte == 8'hFF) begin
                        n_phase = PH_ACKPOST;
                    end else begin
                        n_phase              = PH_HUNT;
                        n_window             = WINDOW_EMPTY;
                        o_has_result         = 1'b1;
                        o_result.result_kind = KIND_ERROR;
                        o_result.error_code  = ERR_LCS;
                    end
                end
                PH_ACKPOST: begin
                    n_phase      = PH_HUNT;
                    n_window     = WINDOW_EMPTY;
                    o_has_result = 1'b1;
                    if (i_rx_byte == 8'h00) begin
                        o_result.result_kind = KIND_ACK;
                    end else begin
                        o_result.result_kind = KIND_ERROR;
                        o_result.error_code  = ERR_LCS;
                    end
                end
                PH_DATA: begin
                    n_sum  = dcs_sum;
                    n_left = left_dec;
                    if (left_dec == 8'h00) begin
                        n_phase = PH_DCS;
                    end
                    o_has_result         = 1'b1;
                    o_result.result_kind = KIND_PAYLOAD;
                    o_result.out_byte    = i_rx_byte;
                    o_result.frame_len   = r_len;
                end
                PH_DCS: begin
                    n_phase      = PH_HUNT;
                    n_window     = WINDOW_EMPTY;
                    o_has_result = 1'b1;
                    if (dcs_sum == 8'h00) begin
                        o_result.result_kind = KIND_GOOD;
                        o_result.frame_len   = r_len;
                    end else begin
                        o_result.result_kind = KIND_ERROR;
                        o_result.error_code  = ERR_DCS;
                    end
                end
                default: begin
                    n_phase  = PH_HUNT;
                    n_window = WINDOW_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 16'h0000;
            r_phase    <= PH_HUNT;
            r_accepted <= 1'b0;
            r_len      <= 8'h00;
            r_left     <= 8'h00;
            r_sum      <= 8'h00;
        end else if (i_step) begin
            r_window   <= n_window;
            r_phase    <= n_phase;
            r_accepted <= n_accepted;
            r_len      <= n_len;
            r_left     <= n_left;
            r_sum      <= n_sum;
        end
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_ACKPOST)
        else $error("parser phase out of range");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != 8'h00)
        else $error("data phase with no payload bytes left");

    a_restart_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_read_start |=> r_phase == PH_HUNT && r_window == WINDOW_EMPTY)
        else $error("read start did not restart the hunt");

    a_refused_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_accepted && !i_read_start |-> !o_has_result)
        else $error("result produced outside an accepted read");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.result_kind == KIND_ERROR
            |-> o_result.error_code != ERR_NONE)
        else $error("error result without an error code");

endmodule

/* hw/rtl/nfcdf_out_reg.sv */
// Result register of the deframer with valid/stall handshake.
// Depends on nfcdf_pkg for the result type.
module nfcdf_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  nfcdf_pkg::t_result  i_data,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output nfcdf_pkg::t_result  o_data
);
    import nfcdf_pkg::*;

    logic    r_valid;
    t_result r_data;

    // The register can take a new result when empty or when its request leaves now.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* hw/rtl/nfc_frame_deframer.sv */
// Top level of the NFC normal-frame deframer: input register, parser, result register.
// Depends on nfcdf_pkg, nfcdf_core and nfcdf_out_reg.
//
// The block takes one received byte per cycle while the input is not stalled, and
// returns at most one result per byte: a payload byte, a good frame end, an ack frame
// or an error. A byte waits in the input register while the parser decides on it, and
// its result is then loaded into the result register; the sustained rate is one byte
// per cycle while no stall holds the input. Bytes that produce no result never wait
// for the output side; a byte that does produce one holds the input register only
// while the result register is full and stalled.
module nfc_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_read_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_frame_len,
    output logic [1:0] o_error_code
);
    import nfcdf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_rx_byte;
    logic       r_read_start;
    logic       in_accept;
    logic       step;
    logic       has_result;
    logic       out_free;
    t_result    step_result;
    t_result    out_data;

    assign step       = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rx_byte    <= i_rx_byte;
            r_read_start <= i_read_start;
        end
    end

    nfcdf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_rx_byte    (r_rx_byte),
        .i_read_start (r_read_start),
        .o_has_result (has_result),
        .o_result     (step_result)
    );

    nfcdf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && has_result),
        .i_data  (step_result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_result_kind = out_data.result_kind;
    assign o_out_byte    = out_data.out_byte;
    assign o_frame_len   = out_data.frame_len;
    assign o_error_code  = out_data.error_code;

endmodule
